FILE: rtl/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// shared widths, register map, method codes and divider handshake of the 2x2 iterative solver
// ----------------------------------------------------------------------------
package ils_pkg;

  // data path widths
  localparam int DATA_W     = 32;             // q format word
  localparam int MUL_W      = DATA_W + 1;     // shared multiplier operand
  localparam int PROD_W     = 2 * MUL_W;      // shared multiplier product
  localparam int DIVIDEND_W = 64;             // numerator magnitude
  localparam int DIVISOR_W  = DATA_W;         // diagonal magnitude
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // configuration register map
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_METHOD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RELAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CAP    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START  = 3'd4;

  // register widths
  localparam int METHOD_W = 2;
  localparam int RELAX_W  = 18;
  localparam int TOL_W    = 17;
  localparam int CAP_W    = 16;

  // method codes, the unused code runs as jacobi
  localparam logic [METHOD_W-1:0] METHOD_JACOBI = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_GS     = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_SOR    = 2'd2;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/ils_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module ils_mul (
  input  logic                                clk,
  input  logic signed [ils_pkg::MUL_W-1:0]    op_a,
  input  logic signed [ils_pkg::MUL_W-1:0]    op_b,
  output logic signed [ils_pkg::PROD_W-1:0]   prod
);

  logic signed [ils_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= ils_pkg::PROD_W'(op_a) * ils_pkg::PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

FILE: rtl/ils_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ils_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ils_pkg::div_req_t req,
  output ils_pkg::div_rsp_t rsp
);

  logic [ils_pkg::DIVIDEND_W-1:0] quo_r;
  logic [ils_pkg::DIVISOR_W-1:0]  rem_r;
  logic [ils_pkg::DIVISOR_W-1:0]  den_r;
  logic [ils_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           run_r;
  logic                           done_r;

  logic [ils_pkg::DIVISOR_W:0]    shifted;
  logic [ils_pkg::DIVISOR_W:0]    trial;
  logic                           fits;

  // shift in next dividend bit, try subtracting the divisor
  assign shifted = {rem_r, quo_r[ils_pkg::DIVIDEND_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = ~trial[ils_pkg::DIVISOR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ils_pkg::DIV_CNT_W'(ils_pkg::DIVIDEND_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      den_r <= req.divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[ils_pkg::DIVIDEND_W-2:0], fits};
      rem_r <= fits ? trial[ils_pkg::DIVISOR_W-1:0] : shifted[ils_pkg::DIVISOR_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: rtl/iterative_linear_solver_2x2_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_linear_solver_2x2_core
// jacobi / gauss-seidel / sor iteration on one 2x2 system in signed q format
// ----------------------------------------------------------------------------
//
//  channel   handshake             beat contents
//  -------   -------------------   -------------------------------------------
//  input     start & !busy         four coefficients, two right-hand values
//  result    out_valid (1 cycle)   two unknowns, sweep count, status flags
//  config    psel/penable/pwrite   method, relax, tolerance, cap, start guess
//
//  steps: each row update is one multiply, one numerator state and a 64-step
//  division on the shared divider, plus the sor relaxation multiply and
//  relax states; one sweep is two rows and a check state, repeated until
//  tolerance or cap; a zero diagonal answers in the cycle after its beat
//  reset: synchronous rst_n low loads the register defaults and idles the block
//  busy stays high from an accepted beat until the cycle its result is shown,
//  but a zero-diagonal beat leaves it low; the result beat is a single-cycle
//  strobe, the receiver cannot stall it
module iterative_linear_solver_2x2_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ils_pkg::DATA_W-1:0] in_coef_row0_col0,
  input  logic signed [ils_pkg::DATA_W-1:0] in_coef_row0_col1,
  input  logic signed [ils_pkg::DATA_W-1:0] in_coef_row1_col0,
  input  logic signed [ils_pkg::DATA_W-1:0] in_coef_row1_col1,
  input  logic signed [ils_pkg::DATA_W-1:0] in_rhs_first,
  input  logic signed [ils_pkg::DATA_W-1:0] in_rhs_second,
  // result channel
  output logic                              out_valid,
  output logic signed [ils_pkg::DATA_W-1:0] out_solution_first,
  output logic signed [ils_pkg::DATA_W-1:0] out_solution_second,
  output logic [ils_pkg::CAP_W-1:0]         out_sweeps_done,
  output logic                              out_converged,
  output logic                              out_zero_diagonal,
  // apb configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ils_pkg::ADDR_W-1:0]        paddr,
  input  logic [ils_pkg::DATA_W-1:0]        pwdata,
  output logic [ils_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int DW = ils_pkg::DATA_W;
  localparam int MW = ils_pkg::MUL_W;
  localparam int PW = ils_pkg::PROD_W;
  localparam int NW = ils_pkg::DIVIDEND_W + 1;   // signed numerator

  // register defaults: 1.5, round(1e-4), 1000, 10.0
  localparam logic [63:0] RELAX_RST64 = 64'd3 << (FRAC_BITS - 1);
  localparam logic [63:0] TOL_RST64   = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] START_RST64 = 64'd10 << FRAC_BITS;
  localparam logic [ils_pkg::CAP_W-1:0] CAP_RST = 16'd1000;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_NUM   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_RMUL  = 7'b0010000,
    S_RELAX = 7'b0100000,
    S_CHECK = 7'b1000000
  } state_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [ils_pkg::METHOD_W-1:0] method_r;
  logic [ils_pkg::RELAX_W-1:0]  relax_r;
  logic [ils_pkg::TOL_W-1:0]    tol_r;
  logic [ils_pkg::CAP_W-1:0]    cap_r;
  logic signed [DW-1:0]         start_guess_r;

  logic                          cfg_wr;
  logic [ils_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ils_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r      <= ils_pkg::METHOD_JACOBI;
      relax_r       <= RELAX_RST64[ils_pkg::RELAX_W-1:0];
      tol_r         <= TOL_RST64[ils_pkg::TOL_W-1:0];
      cap_r         <= CAP_RST;
      start_guess_r <= START_RST64[DW-1:0];
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ils_pkg::REG_METHOD: method_r      <= pwdata[ils_pkg::METHOD_W-1:0];
        ils_pkg::REG_RELAX:  relax_r       <= pwdata[ils_pkg::RELAX_W-1:0];
        ils_pkg::REG_TOL:    tol_r         <= pwdata[ils_pkg::TOL_W-1:0];
        ils_pkg::REG_CAP:    cap_r         <= pwdata[ils_pkg::CAP_W-1:0];
        ils_pkg::REG_START:  start_guess_r <= pwdata;
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ils_pkg::REG_METHOD: prdata = DW'(method_r);
      ils_pkg::REG_RELAX:  prdata = DW'(relax_r);
      ils_pkg::REG_TOL:    prdata = DW'(tol_r);
      ils_pkg::REG_CAP:    prdata = DW'(cap_r);
      ils_pkg::REG_START:  prdata = start_guess_r;
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer state and operands
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic signed [DW-1:0] a00_r, a01_r, a10_r, a11_r, b0_r, b1_r;
  logic signed [DW-1:0] x0_r, x1_r;    // values of the running sweep
  logic signed [DW-1:0] o0_r, o1_r;    // values before the running sweep
  logic signed [DW-1:0] gs_r;          // plain row quotient, kept for sor
  logic                 row_r;         // 0: first unknown, 1: second
  logic                 neg_r;         // sign of the running quotient
  logic [ils_pkg::CAP_W-1:0] sweeps_r;

  logic signed [DW-1:0] out_x0_r, out_x1_r;
  logic [ils_pkg::CAP_W-1:0] out_sweeps_r;
  logic out_conv_r, out_zd_r, out_valid_r;

  logic accept, in_zdiag;
  logic is_sor, newest_other;

  assign accept       = start & ~busy;
  assign in_zdiag     = (in_coef_row0_col0 == '0) | (in_coef_row1_col1 == '0);
  assign is_sor       = (method_r == ils_pkg::METHOD_SOR);
  // gauss-seidel and sor read the freshly written first unknown
  assign newest_other = (method_r == ils_pkg::METHOD_GS) | is_sor;

  // --------------------------------------------------------------------------
  // shared multiplier: off-diagonal product, then relaxation weight
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [DW-1:0] other_x, old_row, diag_row, rhs_row;

  assign other_x  = row_r ? (newest_other ? x0_r : o0_r) : o1_r;
  assign old_row  = row_r ? o1_r : o0_r;
  assign diag_row = row_r ? a11_r : a00_r;
  assign rhs_row  = row_r ? b1_r : b0_r;

  always_comb begin
    if (state_r == S_RMUL) begin
      mul_a = MW'($signed({1'b0, relax_r}));
      mul_b = MW'(gs_r) - MW'(old_row);
    end else begin
      mul_a = MW'(row_r ? a10_r : a01_r);
      mul_b = MW'(other_x);
    end
  end

  ils_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  // --------------------------------------------------------------------------
  // numerator and divider
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  logic [DW-1:0]        diag_mag;
  ils_pkg::div_req_t    div_req;
  ils_pkg::div_rsp_t    div_rsp;

  assign num      = (NW'(rhs_row) <<< FRAC_BITS) - NW'(mul_p);
  assign num_mag  = num[NW-1] ? -num : num;
  assign diag_mag = diag_row[DW-1] ? -diag_row : diag_row;

  assign div_req.start    = (state_r == S_NUM);
  assign div_req.dividend = num_mag[ils_pkg::DIVIDEND_W-1:0];
  assign div_req.divisor  = diag_mag;

  ils_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // quotient magnitude back to a saturated signed word
  logic [ils_pkg::DIVIDEND_W-1:0] q;
  logic signed [DW-1:0]           quot_sat;

  assign q = div_rsp.quotient;

  always_comb begin
    if (neg_r) begin
      if ((|q[ils_pkg::DIVIDEND_W-1:DW]) | (q[DW-1] & (|q[DW-2:0])))
        quot_sat = SAT_MIN;
      else
        quot_sat = -$signed(q[DW-1:0]);
    end else begin
      if (|q[ils_pkg::DIVIDEND_W-1:DW-1])
        quot_sat = SAT_MAX;
      else
        quot_sat = $signed(q[DW-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // sor relaxation: old + floor(w * (gs - old) / 2^frac), saturated
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] relax_sum;
  logic signed [DW-1:0] relax_sat;

  assign relax_sum = (mul_p >>> FRAC_BITS) + PW'(old_row);

  always_comb begin
    if (relax_sum[PW-1:DW-1] == '0 || relax_sum[PW-1:DW-1] == '1)
      relax_sat = relax_sum[DW-1:0];
    else
      relax_sat = relax_sum[PW-1] ? SAT_MIN : SAT_MAX;
  end

  // --------------------------------------------------------------------------
  // end of sweep check
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] max_new, max_old;
  logic signed [DW:0]   delta;
  logic [DW:0]          delta_mag;
  logic [ils_pkg::CAP_W-1:0] cap_eff, sweeps_inc;
  logic conv_now, cap_hit;

  assign max_new    = (x0_r < x1_r) ? x1_r : x0_r;
  assign max_old    = (o0_r < o1_r) ? o1_r : o0_r;
  assign delta      = (DW+1)'(max_new) - (DW+1)'(max_old);
  assign delta_mag  = delta[DW] ? -delta : delta;
  assign conv_now   = delta_mag <= (DW+1)'(tol_r);
  // a cap of zero still runs one sweep
  assign cap_eff    = (cap_r == '0) ? ils_pkg::CAP_W'(1) : cap_r;
  assign sweeps_inc = sweeps_r + 1'b1;
  assign cap_hit    = sweeps_inc >= cap_eff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && !in_zdiag) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_NUM;
      S_NUM:   state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          if (is_sor)     state_nxt = S_RMUL;
          else if (row_r) state_nxt = S_CHECK;
          else            state_nxt = S_MUL;
        end
      end
      S_RMUL:  state_nxt = S_RELAX;
      S_RELAX: state_nxt = row_r ? S_CHECK : S_MUL;
      S_CHECK: state_nxt = (conv_now || cap_hit) ? S_IDLE : S_MUL;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && in_zdiag) ||
                     ((state_r == S_CHECK) && (conv_now || cap_hit));
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a00_r    <= in_coef_row0_col0;
          a01_r    <= in_coef_row0_col1;
          a10_r    <= in_coef_row1_col0;
          a11_r    <= in_coef_row1_col1;
          b0_r     <= in_rhs_first;
          b1_r     <= in_rhs_second;
          x0_r     <= start_guess_r;
          x1_r     <= start_guess_r;
          o0_r     <= start_guess_r;
          o1_r     <= start_guess_r;
          sweeps_r <= '0;
          row_r    <= 1'b0;
          if (in_zdiag) begin
            out_x0_r     <= start_guess_r;
            out_x1_r     <= start_guess_r;
            out_sweeps_r <= '0;
            out_conv_r   <= 1'b0;
            out_zd_r     <= 1'b1;
          end
        end
      end
      S_MUL: ;
      S_NUM: neg_r <= num[NW-1] ^ diag_row[DW-1];
      S_DIV: begin
        if (div_rsp.done) begin
          if (is_sor) begin
            gs_r <= quot_sat;
          end else begin
            if (row_r) x1_r <= quot_sat;
            else       x0_r <= quot_sat;
            row_r <= ~row_r;
          end
        end
      end
      S_RMUL: ;
      S_RELAX: begin
        if (row_r) x1_r <= relax_sat;
        else       x0_r <= relax_sat;
        row_r <= ~row_r;
      end
      S_CHECK: begin
        sweeps_r <= sweeps_inc;
        o0_r     <= x0_r;
        o1_r     <= x1_r;
        if (conv_now || cap_hit) begin
          out_x0_r     <= x0_r;
          out_x1_r     <= x1_r;
          out_sweeps_r <= sweeps_inc;
          out_conv_r   <= conv_now;
          out_zd_r     <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_solution_first  = out_x0_r;
  assign out_solution_second = out_x1_r;
  assign out_sweeps_done     = out_sweeps_r;
  assign out_converged       = out_conv_r;
  assign out_zero_diagonal   = out_zd_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(state_r == S_CHECK)))
    else $error("result beat without an accepted item");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_converged && out_zero_diagonal))
    else $error("converged and zero diagonal both set");

  a_zero_diag_no_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_diagonal) |-> (out_sweeps_done == '0))
    else $error("zero diagonal result reports sweeps");

  a_sweeps_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_diagonal) |->
      (out_sweeps_done != '0) && (out_sweeps_done <= cap_eff))
    else $error("sweep count outside one to cap");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_zdiag) |=> busy)
    else $error("accepted item did not start the sequencer");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the 2x2 iterative solver: every accepted system beat
// is solved again by a bit-true model of the jacobi, gauss-seidel and sor
// sweeps, and each result beat is compared field by field with the oldest
// pending solution; directed corner systems first, then random traffic under
// changing register settings with bursty command timing
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC       = 16;
  localparam int CLK_PERIOD = 12;

  // the slowest correct beat here is a system that runs 1000 sweeps at the
  // reset cap, so a quiet stretch of several times its run means the block hung
  localparam int WATCHDOG_CYCLES = 600000;
  localparam int DRAIN_CYCLES    = 300;

  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 107;

  // signed q16.16 helpers
  localparam logic signed [ils_pkg::DATA_W-1:0] ONE       = 32'sh0001_0000;
  localparam logic signed [ils_pkg::DATA_W-1:0] FIELD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ils_pkg::DATA_W-1:0] FIELD_MIN = 32'sh8000_0000;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  // the spare method code, which must behave as jacobi
  localparam logic [ils_pkg::METHOD_W-1:0] METHOD_SPARE = 2'd3;

  typedef struct {
    logic signed [ils_pkg::DATA_W-1:0] a00, a01, a10, a11, b0, b1;
  } system_t;

  typedef struct {
    logic signed [ils_pkg::DATA_W-1:0] x0, x1;
    logic [ils_pkg::CAP_W-1:0]         sweeps;
    logic                              converged;
    logic                              zero_diag;
  } solution_t;

  // --------------------------------------------------------------------------
  // clock, dut inputs and outputs
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              start = 1'b0;
  logic                              busy;
  logic signed [ils_pkg::DATA_W-1:0] in_coef_row0_col0 = '0;
  logic signed [ils_pkg::DATA_W-1:0] in_coef_row0_col1 = '0;
  logic signed [ils_pkg::DATA_W-1:0] in_coef_row1_col0 = '0;
  logic signed [ils_pkg::DATA_W-1:0] in_coef_row1_col1 = '0;
  logic signed [ils_pkg::DATA_W-1:0] in_rhs_first      = '0;
  logic signed [ils_pkg::DATA_W-1:0] in_rhs_second     = '0;

  logic                              out_valid;
  logic signed [ils_pkg::DATA_W-1:0] out_solution_first;
  logic signed [ils_pkg::DATA_W-1:0] out_solution_second;
  logic [ils_pkg::CAP_W-1:0]         out_sweeps_done;
  logic                              out_converged;
  logic                              out_zero_diagonal;

  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [ils_pkg::ADDR_W-1:0]        paddr   = '0;
  logic [ils_pkg::DATA_W-1:0]        pwdata  = '0;
  logic [ils_pkg::DATA_W-1:0]        prdata;
  logic                              pready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  iterative_linear_solver_2x2_core #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_coef_row0_col0  (in_coef_row0_col0),
    .in_coef_row0_col1  (in_coef_row0_col1),
    .in_coef_row1_col0  (in_coef_row1_col0),
    .in_coef_row1_col1  (in_coef_row1_col1),
    .in_rhs_first       (in_rhs_first),
    .in_rhs_second      (in_rhs_second),
    .out_valid          (out_valid),
    .out_solution_first (out_solution_first),
    .out_solution_second(out_solution_second),
    .out_sweeps_done    (out_sweeps_done),
    .out_converged      (out_converged),
    .out_zero_diagonal  (out_zero_diagonal),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // --------------------------------------------------------------------------
  // register mirror, starts at the reset defaults of the block
  // --------------------------------------------------------------------------
  logic [ils_pkg::METHOD_W-1:0] cfg_method = ils_pkg::METHOD_JACOBI;
  logic [ils_pkg::RELAX_W-1:0]  cfg_relax  = 18'd98304;   // 1.5
  logic [ils_pkg::TOL_W-1:0]    cfg_tol    = 17'd7;       // about 1e-4
  logic [ils_pkg::CAP_W-1:0]    cfg_cap    = 16'd1000;
  logic [ils_pkg::DATA_W-1:0]   cfg_start  = 32'd655360;  // 10.0

  solution_t solutions_due[$];
  int        mismatches   = 0;
  int        quiet_cycles = 0;
  int        burst_left   = 0;

  // --------------------------------------------------------------------------
  // solver model
  // --------------------------------------------------------------------------
  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint larger(longint p, longint q);
    return (p < q) ? q : p;
  endfunction

  // (rhs * 2^frac - off * other) / diag, truncated toward zero, saturated
  function automatic longint row_quotient(longint rhs, longint off, longint diag,
                                          longint other);
    longint      num;
    logic [63:0] mag_n, mag_d, q;
    num   = rhs * (longint'(1) <<< FRAC) - off * other;
    mag_n = (num < 0) ? -num : num;
    mag_d = (diag < 0) ? -diag : diag;
    q     = mag_n / mag_d;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    return clamp_word(((num < 0) != (diag < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic solution_t iterate_system(system_t s);
    solution_t   r;
    longint      a00, a01, a10, a11, b0, b1;
    longint      x0, x1, o0, o1, g0, g1, w, delta, sweep_limit;
    int unsigned sweeps;
    a00 = s.a00;
    a01 = s.a01;
    a10 = s.a10;
    a11 = s.a11;
    b0  = s.b0;
    b1  = s.b1;
    x0  = longint'($signed(cfg_start));
    x1  = x0;
    w   = longint'(cfg_relax);
    sweep_limit = (cfg_cap == '0) ? 1 : longint'(cfg_cap);
    sweeps      = 0;
    r.converged = 1'b0;
    r.zero_diag = (a00 == 0) || (a11 == 0);
    if (!r.zero_diag) begin
      do begin
        o0 = x0;
        o1 = x1;
        if (cfg_method == ils_pkg::METHOD_GS) begin
          x0 = row_quotient(b0, a01, a00, o1);
          x1 = row_quotient(b1, a10, a11, x0);
        end else if (cfg_method == ils_pkg::METHOD_SOR) begin
          // in-place relaxation, the second row sees the relaxed first row
          g0 = row_quotient(b0, a01, a00, o1);
          x0 = clamp_word(o0 + ((w * (g0 - o0)) >>> FRAC));
          g1 = row_quotient(b1, a10, a11, x0);
          x1 = clamp_word(o1 + ((w * (g1 - o1)) >>> FRAC));
        end else begin
          x0 = row_quotient(b0, a01, a00, o1);
          x1 = row_quotient(b1, a10, a11, o0);
        end
        sweeps++;
        delta = larger(x0, x1) - larger(o0, o1);
        if (delta < 0) delta = -delta;
        r.converged = (delta <= longint'(cfg_tol));
      end while (!r.converged && sweeps < sweep_limit);
    end
    r.x0     = x0[ils_pkg::DATA_W-1:0];
    r.x1     = x1[ils_pkg::DATA_W-1:0];
    r.sweeps = sweeps[ils_pkg::CAP_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic system_t make_system(logic signed [ils_pkg::DATA_W-1:0] a00, a01,
                                          a10, a11, b0, b1);
    system_t s;
    s.a00 = a00;
    s.a01 = a01;
    s.a10 = a10;
    s.a11 = a11;
    s.b0  = b0;
    s.b1  = b1;
    return s;
  endfunction

  function automatic logic signed [ils_pkg::DATA_W-1:0] signed_draw(int unsigned lo,
                                                                   int unsigned hi);
    logic signed [ils_pkg::DATA_W-1:0] m;
    m = $urandom_range(lo, hi);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // mostly diagonally dominant systems that converge, some raw noise,
  // and a share with a zero on the diagonal
  function automatic system_t draw_system();
    system_t                           s;
    logic signed [ils_pkg::DATA_W-1:0] mag0, mag1;
    if ($urandom_range(0, 99) < 12) begin
      s.a00 = $urandom();
      s.a01 = $urandom();
      s.a10 = $urandom();
      s.a11 = $urandom();
      s.b0  = $urandom();
      s.b1  = $urandom();
    end else begin
      s.a00 = signed_draw(1 << 10, 1 << 24);
      s.a11 = signed_draw(1 << 10, 1 << 24);
      mag0  = (s.a00 < 0) ? -s.a00 : s.a00;
      mag1  = (s.a11 < 0) ? -s.a11 : s.a11;
      // off-diagonal at most an eighth of the diagonal keeps the sweeps short
      s.a01 = signed_draw(0, mag0 >>> 3);
      s.a10 = signed_draw(0, mag1 >>> 3);
      s.b0  = ($urandom_range(0, 7) == 0) ? $urandom() : signed_draw(0, 1 << 26);
      s.b1  = ($urandom_range(0, 7) == 0) ? $urandom() : signed_draw(0, 1 << 26);
    end
    case ($urandom_range(0, 35))
      0: s.a00 = '0;
      1: s.a11 = '0;
      2: begin
        s.a00 = '0;
        s.a11 = '0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // channel tasks
  // --------------------------------------------------------------------------
  // command beat: start stays high until the block takes it
  task automatic send_system(system_t s);
    start             <= 1'b1;
    in_coef_row0_col0 <= s.a00;
    in_coef_row0_col1 <= s.a01;
    in_coef_row1_col0 <= s.a10;
    in_coef_row1_col1 <= s.a11;
    in_rhs_first      <= s.b0;
    in_rhs_second     <= s.b1;
    do begin
      @(posedge clk);
    end while (busy);
    solutions_due.push_back(iterate_system(s));
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // sender bursts: a random run of back-to-back beats, then usually a gap
  // long enough to land anywhere inside a sweep
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        hold_off($urandom_range(1, 700));
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (solutions_due.size() != 0 || busy) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, register loads on the access edge
  task automatic write_register(logic [ils_pkg::REG_IDX_W-1:0] idx,
                                logic [ils_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      ils_pkg::REG_METHOD: cfg_method = value[ils_pkg::METHOD_W-1:0];
      ils_pkg::REG_RELAX:  cfg_relax  = value[ils_pkg::RELAX_W-1:0];
      ils_pkg::REG_TOL:    cfg_tol    = value[ils_pkg::TOL_W-1:0];
      ils_pkg::REG_CAP:    cfg_cap    = value[ils_pkg::CAP_W-1:0];
      ils_pkg::REG_START:  cfg_start  = value;
      default:             ;
    endcase
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic flag_field(string field, logic signed [63:0] expected,
                            logic signed [63:0] actual);
    mismatches++;
    $error("%s: expected %0d, actual %0d", field, expected, actual);
  endtask

  // the result beat lasts one cycle and cannot be held off
  always @(posedge clk) begin
    solution_t due;
    if (rst_n && out_valid) begin
      if (solutions_due.size() == 0) begin
        mismatches++;
        $error("result beat with no solution pending");
      end else begin
        due = solutions_due.pop_front();
        if (out_solution_first !== due.x0)
          flag_field("solution_first", 64'(due.x0), 64'(out_solution_first));
        if (out_solution_second !== due.x1)
          flag_field("solution_second", 64'(due.x1), 64'(out_solution_second));
        if (out_sweeps_done !== due.sweeps)
          flag_field("sweeps_done", 64'(due.sweeps), 64'(out_sweeps_done));
        if (out_converged !== due.converged)
          flag_field("converged", 64'(due.converged), 64'(out_converged));
        if (out_zero_diagonal !== due.zero_diag)
          flag_field("zero_diagonal", 64'(due.zero_diag), 64'(out_zero_diagonal));
      end
    end
  end

  // watchdog on stretches where no beat of any channel moves
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[iterative_linear_solver_2x2_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // reset settings: jacobi, tolerance 7, cap 1000, both unknowns start at 10.0
  task automatic test_reset_defaults();
    send_system(make_system(4 * ONE, ONE, ONE, 3 * ONE, ONE, 2 * ONE));
    // identity with the start guess as answer settles after one sweep
    send_system(make_system(ONE, 0, 0, ONE, 10 * ONE, 10 * ONE));
    // zero on the diagonal answers at once with the start guess
    send_system(make_system(0, ONE, ONE, 3 * ONE, ONE, ONE));
    send_system(make_system(5 * ONE, -2 * ONE, ONE, 0, -3 * ONE, 7 * ONE));
    drain_results();
  endtask

  // every method code on two converging systems, then sor weight extremes
  task automatic test_methods();
    logic [ils_pkg::METHOD_W-1:0] codes [4];
    codes = '{ils_pkg::METHOD_JACOBI, ils_pkg::METHOD_GS, ils_pkg::METHOD_SOR,
              METHOD_SPARE};
    write_register(ils_pkg::REG_CAP, 64);
    foreach (codes[k]) begin
      write_register(ils_pkg::REG_METHOD, ils_pkg::DATA_W'(codes[k]));
      send_system(make_system(4 * ONE, ONE, ONE, 3 * ONE, ONE, 2 * ONE));
      send_system(make_system(-5 * ONE, 2 * ONE, ONE, -4 * ONE, 3 * ONE, -7 * ONE));
      drain_results();
    end
    write_register(ils_pkg::REG_METHOD, ils_pkg::DATA_W'(ils_pkg::METHOD_SOR));
    // weight zero freezes the unknowns, 2.0 is the top of the range,
    // all ones is beyond it
    write_register(ils_pkg::REG_RELAX, 0);
    send_system(make_system(4 * ONE, ONE, ONE, 3 * ONE, ONE, 2 * ONE));
    drain_results();
    write_register(ils_pkg::REG_RELAX, 131072);
    send_system(make_system(4 * ONE, ONE, ONE, 3 * ONE, ONE, 2 * ONE));
    drain_results();
    write_register(ils_pkg::REG_RELAX, 32'h3FFFF);
    send_system(make_system(-5 * ONE, 2 * ONE, ONE, -4 * ONE, 3 * ONE, -7 * ONE));
    drain_results();
  endtask

  // field extremes, quotient and relaxation saturation, cap of zero,
  // tolerance at the top of its range
  task automatic test_field_extremes();
    write_register(ils_pkg::REG_METHOD, ils_pkg::DATA_W'(ils_pkg::METHOD_JACOBI));
    write_register(ils_pkg::REG_CAP, 0);
    write_register(ils_pkg::REG_TOL, 32'h1FFFF);
    write_register(ils_pkg::REG_START, FIELD_MIN);
    send_system(make_system(FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MAX,
                            FIELD_MIN));
    send_system(make_system(1, 0, -1, -1, FIELD_MAX, FIELD_MIN));
    send_system(make_system(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                            FIELD_MAX));
    send_system(make_system(-1, -1, -1, -1, -1, -1));
    drain_results();
    write_register(ils_pkg::REG_METHOD, ils_pkg::DATA_W'(ils_pkg::METHOD_GS));
    write_register(ils_pkg::REG_CAP, 3);
    write_register(ils_pkg::REG_TOL, 0);
    send_system(make_system(FIELD_MIN, FIELD_MIN, FIELD_MAX, 1, FIELD_MIN, FIELD_MAX));
    drain_results();
    write_register(ils_pkg::REG_METHOD, ils_pkg::DATA_W'(ils_pkg::METHOD_SOR));
    write_register(ils_pkg::REG_RELAX, 32'h3FFFF);
    write_register(ils_pkg::REG_START, FIELD_MAX);
    send_system(make_system(1, FIELD_MAX, FIELD_MIN, -1, FIELD_MIN, FIELD_MAX));
    send_system(make_system(-ONE, ONE, ONE, ONE, FIELD_MAX, FIELD_MIN));
    drain_results();
  endtask

  // bits above each register's width are dropped, the largest cap is usable,
  // and addresses past the last register change nothing
  task automatic test_register_map();
    write_register(ils_pkg::REG_METHOD, {30'h3FFF_FFFF, ils_pkg::METHOD_JACOBI});
    write_register(ils_pkg::REG_RELAX, {14'h3FFF, 18'd65536});
    write_register(ils_pkg::REG_TOL, {15'h7FFF, 17'd0});
    write_register(ils_pkg::REG_CAP, 32'hFFFF_FFFF);
    write_register(ils_pkg::REG_START, 3 * ONE);
    send_system(make_system(ONE, 0, 0, ONE, 3 * ONE, 3 * ONE));
    drain_results();
    write_register(ils_pkg::REG_CAP, 5);
    write_register(ils_pkg::REG_METHOD, ils_pkg::DATA_W'(ils_pkg::METHOD_GS));
    for (int idx = ils_pkg::REG_START + 1; idx < (1 << ils_pkg::REG_IDX_W); idx++) begin
      write_register(idx[ils_pkg::REG_IDX_W-1:0], $urandom());
    end
    send_system(make_system(4 * ONE, ONE, ONE, 3 * ONE, ONE, 2 * ONE));
    drain_results();
  endtask

  // one random setting per phase, junk sometimes in the unused upper bits
  task automatic randomize_setup();
    logic [ils_pkg::DATA_W-1:0]  junk;
    logic [ils_pkg::RELAX_W-1:0] relax;
    logic [ils_pkg::TOL_W-1:0]   tol;
    logic [ils_pkg::CAP_W-1:0]   cap;
    logic [ils_pkg::DATA_W-1:0]  guess;
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
    case ($urandom_range(0, 3))
      0: relax = '0;
      1: relax = 18'd131072;
      2: relax = ils_pkg::RELAX_W'($urandom_range(0, 18'h3FFFF));
      default: relax = ils_pkg::RELAX_W'($urandom_range(16384, 114688));
    endcase
    case ($urandom_range(0, 3))
      0: tol = '0;
      1: tol = 17'd65536;
      2: tol = ils_pkg::TOL_W'($urandom_range(0, 64));
      default: tol = ils_pkg::TOL_W'($urandom_range(0, 17'h1FFFF));
    endcase
    // short caps keep the sweep count, and so the run, bounded
    case ($urandom_range(0, 9))
      0: cap = '0;
      1: cap = 16'd24;
      default: cap = ils_pkg::CAP_W'($urandom_range(1, 10));
    endcase
    case ($urandom_range(0, 4))
      0: guess = FIELD_MIN;
      1: guess = FIELD_MAX;
      2: guess = $urandom();
      default: guess = signed_draw(0, 1 << 20);
    endcase
    write_register(ils_pkg::REG_METHOD, (junk << ils_pkg::METHOD_W) | $urandom_range(0, 3));
    write_register(ils_pkg::REG_RELAX, (junk << ils_pkg::RELAX_W) |
                                       ils_pkg::DATA_W'(relax));
    write_register(ils_pkg::REG_TOL, (junk << ils_pkg::TOL_W) | ils_pkg::DATA_W'(tol));
    write_register(ils_pkg::REG_CAP, (junk << ils_pkg::CAP_W) | ils_pkg::DATA_W'(cap));
    write_register(ils_pkg::REG_START, guess);
  endtask

  // bursty random traffic, with one full pause for the pipeline to empty
  // somewhere inside every phase
  task automatic test_random_traffic();
    int unsigned pause_at;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      randomize_setup();
      pause_at = $urandom_range(1, ITEMS_PER_PHASE - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == pause_at) drain_results();
        else pace_sender();
        send_system(draw_system());
      end
      drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_methods();
    test_field_extremes();
    test_register_map();
    test_random_traffic();
    // all beats in, wait out any stray result before the verdict
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && solutions_due.size() == 0) begin
      $display("[iterative_linear_solver_2x2_core] OK");
    end else begin
      $display("[iterative_linear_solver_2x2_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ils_pkg.sv
rtl/ils_mul.sv
rtl/ils_div.sv
rtl/iterative_linear_solver_2x2_core.sv
dv/testbench.sv
